// File: hw/rtl/rist_pkg.sv
// Shared types and codes for the reference-counted slot table.
// Holds the slot entry layout, the result layout, and the opcode and status codes.
// Has no dependencies. Every other file in the block imports it.
`timescale 1ns / 1ps

package rist_pkg;

    localparam int TAG_W      = 16;
    localparam int CNT_W      = 16;
    localparam int IO_SLOT_W  = 6;
    localparam int STATUS_W   = 3;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // request kinds
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_HIT       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FILL      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_RELEASED  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_WRITEBACK = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_IGNORED   = 3'd5;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [CNT_W-1:0] count;
    } slot_entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [IO_SLOT_W-1:0] slot;
        logic [TAG_W-1:0]     tag;
        logic [CNT_W-1:0]     count;
    } result_t;

endpackage

// File: hw/rtl/rist_slot_mem.sv
// Slot store: one entry per slot holding the tag and the reference count.
// Single write port, single read port; the read data is registered.
// Depends on rist_pkg for the entry layout.
`timescale 1ns / 1ps

module rist_slot_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  rist_pkg::slot_entry_t wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output rist_pkg::slot_entry_t rd_data
);
    import rist_pkg::*;

    slot_entry_t mem [DEPTH];
    slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/rist_engine.sv
// Request sequencer: clears the slot store after reset, scans it for get requests,
// reads a single slot for in-range put requests, then writes back and hands over the result.
// Depends on rist_pkg; drives the ports of rist_slot_mem.
`timescale 1ns / 1ps

module rist_engine #(
    parameter int SLOT_COUNT = 64,
    parameter int SLOT_W     = 6
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 in_opcode,
    input  logic [rist_pkg::TAG_W-1:0]           in_tag,
    input  logic [rist_pkg::IO_SLOT_W-1:0]       in_slot,
    input  logic                                 out_free,
    output logic                                 res_valid,
    output rist_pkg::result_t                    res,
    output logic                                 mem_rd_en,
    output logic [SLOT_W-1:0]                    mem_rd_addr,
    input  rist_pkg::slot_entry_t                mem_rd_data,
    output logic                                 mem_wr_en,
    output logic [SLOT_W-1:0]                    mem_wr_addr,
    output rist_pkg::slot_entry_t                mem_wr_data
);
    import rist_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_PUTRD  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOT_COUNT - 1);

    logic [2:0]           state_reg, state_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic                 op_reg, op_next;
    logic [TAG_W-1:0]     req_tag_reg, req_tag_next;
    logic [IO_SLOT_W-1:0] req_slot_reg, req_slot_next;
    logic                 inrange_reg, inrange_next;
    logic                 hit_reg, hit_next;
    logic [SLOT_W-1:0]    hit_idx_reg, hit_idx_next;
    logic                 free_found_reg, free_found_next;
    logic [SLOT_W-1:0]    free_idx_reg, free_idx_next;
    slot_entry_t          ent_reg, ent_next;

    logic                 in_inrange;
    logic                 q_used;
    logic                 q_match;
    logic [SLOT_W-1:0]    idx_inc;
    logic [CNT_W-1:0]     cnt_inc;
    logic [CNT_W-1:0]     cnt_dec;
    result_t              fin_res;
    logic                 fin_wr_en;
    logic [SLOT_W-1:0]    fin_wr_addr;
    slot_entry_t          fin_wr_data;

    assign in_ready   = (state_reg == S_IDLE);
    assign in_inrange = ({26'd0, in_slot} < 32'(SLOT_COUNT));
    assign q_used     = (mem_rd_data.count != '0);
    assign q_match    = q_used && (mem_rd_data.tag == req_tag_reg);
    assign idx_inc    = SLOT_W'(idx_reg + 1'b1);
    assign cnt_inc    = (ent_reg.count == COUNT_MAX) ? ent_reg.count
                                                     : CNT_W'(ent_reg.count + 1'b1);
    assign cnt_dec    = CNT_W'(ent_reg.count - 1'b1);

    // result and write-back of the item in hand
    always_comb
    begin
        fin_res     = '0;
        fin_wr_en   = 1'b0;
        fin_wr_addr = SLOT_W'(req_slot_reg);
        fin_wr_data = '0;
        if (op_reg == OP_GET)
        begin
            if (hit_reg)
            begin
                fin_res.status    = STAT_HIT;
                fin_res.slot      = IO_SLOT_W'(hit_idx_reg);
                fin_res.tag       = ent_reg.tag;
                fin_res.count     = cnt_inc;
                fin_wr_en         = 1'b1;
                fin_wr_addr       = hit_idx_reg;
                fin_wr_data.tag   = ent_reg.tag;
                fin_wr_data.count = cnt_inc;
            end
            else if (free_found_reg)
            begin
                fin_res.status    = STAT_FILL;
                fin_res.slot      = IO_SLOT_W'(free_idx_reg);
                fin_res.tag       = req_tag_reg;
                fin_res.count     = CNT_W'(1);
                fin_wr_en         = 1'b1;
                fin_wr_addr       = free_idx_reg;
                fin_wr_data.tag   = req_tag_reg;
                fin_wr_data.count = CNT_W'(1);
            end
            else
            begin
                fin_res.status = STAT_FULL;
            end
        end
        else
        begin
            fin_res.slot = req_slot_reg;
            if (!inrange_reg || ent_reg.count == '0)
            begin
                fin_res.status = STAT_IGNORED;
            end
            else
            begin
                fin_res.status    = (cnt_dec == '0) ? STAT_WRITEBACK : STAT_RELEASED;
                fin_res.tag       = ent_reg.tag;
                fin_res.count     = cnt_dec;
                fin_wr_en         = 1'b1;
                fin_wr_data.tag   = ent_reg.tag;
                fin_wr_data.count = cnt_dec;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        req_tag_next    = req_tag_reg;
        req_slot_next   = req_slot_reg;
        inrange_next    = inrange_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        ent_next        = ent_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = idx_inc;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = idx_reg;
        mem_wr_data     = '0;
        res_valid       = 1'b0;
        res             = fin_res;
        case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en = 1'b1;
                idx_next  = idx_inc;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = in_opcode;
                    req_tag_next    = in_tag;
                    req_slot_next   = in_slot;
                    inrange_next    = in_inrange;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    idx_next        = '0;
                    if (in_opcode == OP_GET)
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                        state_next  = S_SCAN;
                    end
                    else if (in_inrange)
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = SLOT_W'(in_slot);
                        state_next  = S_PUTRD;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN:
            begin
                // read data belongs to idx_reg; next address is issued alongside
                if (q_match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = idx_reg;
                    ent_next     = mem_rd_data;
                    state_next   = S_FINISH;
                end
                else
                begin
                    if (!q_used && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        mem_rd_en = 1'b1;
                        idx_next  = idx_inc;
                    end
                end
            end
            S_PUTRD:
            begin
                ent_next   = mem_rd_data;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    res_valid   = 1'b1;
                    mem_wr_en   = fin_wr_en;
                    mem_wr_addr = fin_wr_addr;
                    mem_wr_data = fin_wr_data;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        req_tag_reg    <= req_tag_next;
        req_slot_reg   <= req_slot_next;
        inrange_reg    <= inrange_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        ent_reg        <= ent_next;
    end

    // a result is only handed over when the output stage can take it
    a_res_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_free)
        else $error("result issued while output stage occupied");

    // scan never reads and writes the store in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en))
        else $error("slot store read and written together");

    // after a result the next item can be taken straight away
    a_ready_after_res: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> in_ready)
        else $error("not ready after result");

    // a fresh claim always starts at a count of one and writes it back
    a_fill_count_one: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == STAT_FILL) |->
            (res.count == CNT_W'(1) && mem_wr_en && mem_wr_data.count == CNT_W'(1)))
        else $error("fill with wrong count");

endmodule

// File: hw/rtl/refcounted_inode_slot_table.sv
// Reference-counted slot table, top level. Get: scans the slot store from accept to result
// (one slot store read per cycle, stopping early on a hit); put: reads the named slot, if in range.
// One item at a time: the next item can be accepted the cycle after a result is produced.
// The output register lets a new item enter while the last result waits to be taken.
// After rst_n (asynchronous, active low) a clearing pass zeroes every count; s_tready stays
// low meanwhile. Depends on rist_pkg, rist_engine, rist_slot_mem.
`timescale 1ns / 1ps

module refcounted_inode_slot_table #(
    parameter int SLOT_COUNT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // tag_number [15:0], slot_index [21:16], zero [23:22]
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // result_slot [5:0], result_tag [21:6],
                                   // result_count [37:22], zero [39:38]
    output logic [2:0]  m_tuser    // status
);
    import rist_pkg::*;

    localparam int SLOT_W = $clog2(SLOT_COUNT);

    logic              out_free;
    logic              res_valid;
    result_t           res;
    logic              mem_rd_en;
    logic [SLOT_W-1:0] mem_rd_addr;
    slot_entry_t       mem_rd_data;
    logic              mem_wr_en;
    logic [SLOT_W-1:0] mem_wr_addr;
    slot_entry_t       mem_wr_data;

    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;

    rist_engine #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_opcode   (s_tuser),
        .in_tag      (s_tdata[15:0]),
        .in_slot     (s_tdata[21:16]),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    rist_slot_mem #(
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (SLOT_W)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // output register
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {2'b00, out_reg.count, out_reg.tag, out_reg.slot};

endmodule
